[hw/rtl/lpht_pkg.sv]
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = $clog2(MAX_SLOTS + 1);
    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 64;
    localparam int OP_W      = 2;
    localparam int RES_W     = 3;

    // Byte sum of an 8-byte key and the bit counter of the remainder unit.
    localparam int KEY_BYTES = KEY_W / 8;
    localparam int SUM_W     = $clog2(KEY_BYTES * 255 + 1);
    localparam int BIT_CNT_W = $clog2(SUM_W);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [RES_W-1:0] RES_INSERTED  = 3'd0;
    localparam logic [RES_W-1:0] RES_FULL      = 3'd1;
    localparam logic [RES_W-1:0] RES_FOUND     = 3'd2;
    localparam logic [RES_W-1:0] RES_NOT_FOUND = 3'd3;
    localparam logic [RES_W-1:0] RES_DELETED   = 3'd4;
    localparam logic [RES_W-1:0] RES_INVALID   = 3'd5;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_LIVE    = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    localparam int REG_TABLE_SIZE = 0;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(MAX_SLOTS);

    typedef struct packed {
        logic [1:0]         state;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] home;
    } hash_rsp_t;

endpackage

[hw/rtl/lpht_ram.sv]
`timescale 1ns / 1ps

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/lpht_hash.sv]
`timescale 1ns / 1ps

module lpht_hash (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lpht_pkg::KEY_W-1:0]        key,
    input  logic [lpht_pkg::SIZE_W-1:0]       size,
    output lpht_pkg::hash_rsp_t               rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [lpht_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [lpht_pkg::SIZE_W-1:0]       rem_reg, rem_next;
    logic [lpht_pkg::BIT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [lpht_pkg::SUM_W-1:0]        byte_sum;
    logic [lpht_pkg::SIZE_W:0]         trial;
    logic [lpht_pkg::SIZE_W:0]         diff;

    always_comb
    begin
        byte_sum = '0;
        for (int b = 0; b < lpht_pkg::KEY_BYTES; b++)
        begin
            byte_sum = byte_sum + lpht_pkg::SUM_W'(key[8*b +: 8]);
        end
    end

    // Restoring remainder, one bit of the byte sum per cycle, MSB first.
    assign trial = {rem_reg, sum_reg[lpht_pkg::SUM_W-1]};
    assign diff  = trial - {1'b0, size};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sum_next  = sum_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            sum_next  = byte_sum;
            rem_next  = '0;
            cnt_next  = lpht_pkg::BIT_CNT_W'(lpht_pkg::SUM_W - 1);
        end
        else if (busy_reg)
        begin
            sum_next = {sum_reg[lpht_pkg::SUM_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, size}) ? diff[lpht_pkg::SIZE_W-1:0]
                                              : trial[lpht_pkg::SIZE_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.home = rem_reg[lpht_pkg::SLOT_W-1:0];

endmodule

[hw/rtl/lpht_probe.sv]
`timescale 1ns / 1ps

module lpht_probe (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lpht_pkg::SIZE_W-1:0]       size,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lpht_pkg::OP_W-1:0]         operation,
    input  logic [lpht_pkg::KEY_W-1:0]        key,
    input  logic [lpht_pkg::VALUE_W-1:0]      value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lpht_pkg::RES_W-1:0]        status,
    output logic [lpht_pkg::VALUE_W-1:0]      found_value,
    output logic [lpht_pkg::SLOT_W-1:0]       slot
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HASH   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam int EW = $bits(lpht_pkg::entry_t);

    logic [2:0]                         state_reg, state_next;
    logic [lpht_pkg::OP_W-1:0]          op_reg, op_next;
    logic [lpht_pkg::KEY_W-1:0]         key_reg, key_next;
    logic [lpht_pkg::VALUE_W-1:0]       value_reg, value_next;
    logic [lpht_pkg::SLOT_W-1:0]        idx_reg, idx_next;
    logic [lpht_pkg::SIZE_W-1:0]        cnt_reg, cnt_next;
    logic [lpht_pkg::SIZE_W-1:0]        live_reg, live_next;
    logic [lpht_pkg::MAX_SLOTS-1:0]     valid_reg, valid_next;
    logic [lpht_pkg::RES_W-1:0]         res_status_reg, res_status_next;
    logic [lpht_pkg::VALUE_W-1:0]       res_value_reg, res_value_next;
    logic [lpht_pkg::SLOT_W-1:0]        res_slot_reg, res_slot_next;
    logic                               out_valid_reg, out_valid_next;
    logic [lpht_pkg::RES_W-1:0]         out_status_reg, out_status_next;
    logic [lpht_pkg::VALUE_W-1:0]       out_value_reg, out_value_next;
    logic [lpht_pkg::SLOT_W-1:0]        out_slot_reg, out_slot_next;

    logic                               accept;
    logic                               hash_start;
    lpht_pkg::hash_rsp_t                hash_rsp;
    logic                               ram_we;
    logic                               ram_re;
    lpht_pkg::entry_t                   wr_entry;
    lpht_pkg::entry_t                   rd_entry;
    logic [EW-1:0]                      rd_bits;
    logic [1:0]                         cur_state;
    logic [lpht_pkg::SIZE_W-1:0]        idx_inc;
    logic [lpht_pkg::SIZE_W-1:0]        cnt_inc;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign rd_entry = lpht_pkg::entry_t'(rd_bits);

    // Entries never written since reset read as empty.
    assign cur_state = valid_reg[idx_reg] ? rd_entry.state : lpht_pkg::SLOT_EMPTY;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign cnt_inc   = cnt_reg + 1'b1;

    lpht_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .size  (size),
        .rsp   (hash_rsp)
    );

    lpht_ram #(
        .WIDTH (EW),
        .DEPTH (lpht_pkg::MAX_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (rd_bits)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        live_next       = live_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_slot_next   = out_slot_reg;
        hash_start      = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        wr_entry        = '{state: lpht_pkg::SLOT_LIVE, key: key_reg, value: value_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = operation;
                    key_next        = key;
                    value_next      = value;
                    res_value_next  = '0;
                    res_slot_next   = '0;
                    if (key == '0 || !(operation == lpht_pkg::OP_INSERT ||
                        operation == lpht_pkg::OP_LOOKUP || operation == lpht_pkg::OP_DELETE))
                    begin
                        res_status_next = lpht_pkg::RES_INVALID;
                        state_next      = S_FINISH;
                    end
                    else if (operation == lpht_pkg::OP_INSERT && live_reg >= size)
                    begin
                        res_status_next = lpht_pkg::RES_FULL;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_rsp.done)
                begin
                    idx_next   = hash_rsp.home;
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // The slot is written back here, before the next read is issued.
                state_next = S_READ;
                idx_next   = (idx_inc == size) ? '0 : idx_inc[lpht_pkg::SLOT_W-1:0];
                cnt_next   = cnt_inc;
                if (op_reg == lpht_pkg::OP_INSERT && cur_state != lpht_pkg::SLOT_LIVE)
                begin
                    ram_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    live_next           = live_reg + 1'b1;
                    res_status_next     = lpht_pkg::RES_INSERTED;
                    res_slot_next       = idx_reg;
                    idx_next            = idx_reg;
                    state_next          = S_FINISH;
                end
                else if (op_reg != lpht_pkg::OP_INSERT && cur_state == lpht_pkg::SLOT_EMPTY)
                begin
                    res_status_next = lpht_pkg::RES_NOT_FOUND;
                    idx_next        = idx_reg;
                    state_next      = S_FINISH;
                end
                else if (op_reg != lpht_pkg::OP_INSERT && cur_state == lpht_pkg::SLOT_LIVE &&
                         rd_entry.key == key_reg)
                begin
                    res_slot_next = idx_reg;
                    idx_next      = idx_reg;
                    state_next    = S_FINISH;
                    if (op_reg == lpht_pkg::OP_LOOKUP)
                    begin
                        res_status_next = lpht_pkg::RES_FOUND;
                        res_value_next  = rd_entry.value;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        wr_entry        = '{state: lpht_pkg::SLOT_DELETED, key: rd_entry.key,
                                            value: '0};
                        res_status_next = lpht_pkg::RES_DELETED;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - 1'b1;
                        end
                    end
                end
                else if (cnt_inc == size)
                begin
                    res_status_next = (op_reg == lpht_pkg::OP_INSERT) ? lpht_pkg::RES_FULL
                                                                     : lpht_pkg::RES_NOT_FOUND;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_slot_reg   <= out_slot_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_value = out_value_reg;
    assign slot        = out_slot_reg;

endmodule

[hw/rtl/linear_probe_hash_table_top.sv]
`timescale 1ns / 1ps

// Open-addressing key/value table with linear probing, 16 slots.
// Requests arrive on the s_ stream: each beat carries an operation (insert,
// lookup, delete), a 64-bit key and a 64-bit value. Every request gives
// exactly one result beat on the m_ stream: status, found value and slot.
// The table size register sits at APB address 0; pready is always high. The
// register is to be written only while no request is in flight; the block
// itself does not enforce this.
// A request with key zero, an unknown operation or an insert into a full
// table skips the hash and the probe and goes to the output register.
// Otherwise the byte sum is loaded at acceptance, the remainder unit then
// works one of its 11 bits per cycle and hands the home slot over, and the
// slots are probed through the table RAM's read-check-write loop before the
// result goes to the output register. One request is in work at a time, and
// the next one can be taken in the cycle after the result is loaded.
// A finished result waits in the output register while the receiver stalls;
// the next request is taken meanwhile and holds in its last step until the
// output register frees up.
// Reset empties every slot (per-slot valid bits), clears the live count and
// sets the table size to 16. No clearing pass is needed.

module linear_probe_hash_table_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // operation[1:0], key[65:2], value[129:66], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // status[2:0], found_value[66:3], slot[70:67], zero pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [lpht_pkg::SIZE_W-1:0]  table_size_reg, table_size_next;
    logic [lpht_pkg::SIZE_W-1:0]  eff_size;
    logic                         reg_sel;
    logic [lpht_pkg::RES_W-1:0]   status;
    logic [lpht_pkg::VALUE_W-1:0] found_value;
    logic [lpht_pkg::SLOT_W-1:0]  slot;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'(lpht_pkg::REG_TABLE_SIZE));

    always_comb
    begin
        table_size_next = table_size_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            table_size_next = pwdata[lpht_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= lpht_pkg::TABLE_SIZE_RESET;
        end
        else
        begin
            table_size_reg <= table_size_next;
        end
    end

    assign prdata = reg_sel ? {(32 - lpht_pkg::SIZE_W)'(0), table_size_reg} : '0;

    // Zero acts as one slot, anything above the slot count as the full table.
    always_comb
    begin
        priority if (table_size_reg == '0)
        begin
            eff_size = lpht_pkg::SIZE_W'(1);
        end
        else if (table_size_reg > lpht_pkg::SIZE_W'(lpht_pkg::MAX_SLOTS))
        begin
            eff_size = lpht_pkg::SIZE_W'(lpht_pkg::MAX_SLOTS);
        end
        else
        begin
            eff_size = table_size_reg;
        end
    end

    lpht_probe u_probe (
        .clk         (clk),
        .rst_n       (rst_n),
        .size        (eff_size),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .operation   (s_tdata[1:0]),
        .key         (s_tdata[65:2]),
        .value       (s_tdata[129:66]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .status      (status),
        .found_value (found_value),
        .slot        (slot)
    );

    assign m_tdata = {1'b0, slot, found_value, status};

endmodule

[hw/rtl/lpht_checker.sv]
`timescale 1ns / 1ps

module lpht_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata
);

    logic [2:0] res;

    assign res = m_tdata[2:0];

    // One request is worked on at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res == lpht_pkg::RES_INSERTED || res == lpht_pkg::RES_FULL ||
                      res == lpht_pkg::RES_FOUND || res == lpht_pkg::RES_NOT_FOUND ||
                      res == lpht_pkg::RES_DELETED || res == lpht_pkg::RES_INVALID))
        else $error("undefined status code");

    a_value_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res != lpht_pkg::RES_FOUND |-> m_tdata[66:3] == '0)
        else $error("found value set without a hit");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res == lpht_pkg::RES_FULL || res == lpht_pkg::RES_NOT_FOUND ||
                     res == lpht_pkg::RES_INVALID) |-> m_tdata[70:67] == '0)
        else $error("slot set on a miss");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import lpht_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 64;
    localparam int ITEMS_PER_PHASE  = 155;
    localparam int NUM_PHASES       = 8;
    localparam int NAME_POOL        = 20;
    localparam logic [63:0] ONES64  = {64{1'b1}};

    typedef struct packed {
        logic [RES_W-1:0]   status;
        logic [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]  slot;
    } answer_t;

    typedef struct {
        bit                 sets_size;
        logic [SIZE_W-1:0]  size_val;
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] val;
        bit                 typed;
        answer_t            ans;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // operation[1:0], key[65:2], value[129:66], zero pad
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // status[2:0], found_value[66:3], slot[70:67], zero pad
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copy of the table contents and the size register.
    logic [1:0]         bkt_state [MAX_SLOTS];
    logic [KEY_W-1:0]   bkt_key   [MAX_SLOTS];
    logic [VALUE_W-1:0] bkt_val   [MAX_SLOTS];
    int unsigned        live_entries;
    logic [SIZE_W-1:0]  size_reg;

    answer_t      answer_q [$];
    dir_row_t     dir_rows [$];
    logic [63:0]  name_pool [NAME_POOL];
    int           phase_size [NUM_PHASES] = '{16, 1, 5, 31, 0, 9, 16, 3};
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           errors = 0;
    int           idle_cycles = 0;
    answer_t      head_ans;

    linear_probe_hash_table_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Works out the answer to one request and updates the shadow table.
    function automatic answer_t predict_table_op(input logic [OP_W-1:0] op,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [VALUE_W-1:0] val);
        answer_t     r;
        int unsigned span;
        int unsigned idx;
        int unsigned sum;
        int unsigned n;
        int          b;
        bit          done;
        bit          hit;
        r.status = RES_INVALID;
        r.value  = '0;
        r.slot   = '0;
        if (size_reg == 0)
            span = 1;
        else if (size_reg > MAX_SLOTS)
            span = MAX_SLOTS;
        else
            span = size_reg;
        sum = 0;
        for (b = 0; b < KEY_BYTES; b++)
            sum += key[8*b +: 8];
        idx = sum % span;
        done = 1'b0;
        hit = 1'b0;
        if (key == '0) begin
        end
        else if (op == OP_INSERT)
        begin
            r.status = RES_FULL;
            if (live_entries < span)
            begin
                for (n = 0; n < span && !done; n++)
                begin
                    if (bkt_state[idx] != SLOT_LIVE)
                    begin
                        bkt_state[idx] = SLOT_LIVE;
                        bkt_key[idx]   = key;
                        bkt_val[idx]   = val;
                        live_entries++;
                        r.status = RES_INSERTED;
                        r.slot   = SLOT_W'(idx);
                        done = 1'b1;
                    end
                    else
                        idx = (idx + 1 == span) ? 0 : idx + 1;
                end
            end
        end
        else if (op == OP_LOOKUP || op == OP_DELETE)
        begin
            // Deleted slots are skipped; an empty one ends the search.
            for (n = 0; n < span && !done; n++)
            begin
                if (bkt_state[idx] == SLOT_EMPTY)
                    done = 1'b1;
                else if (bkt_state[idx] == SLOT_LIVE && bkt_key[idx] == key)
                begin
                    done = 1'b1;
                    hit = 1'b1;
                end
                else
                    idx = (idx + 1 == span) ? 0 : idx + 1;
            end
            if (!hit)
                r.status = RES_NOT_FOUND;
            else if (op == OP_LOOKUP)
            begin
                r.status = RES_FOUND;
                r.value  = bkt_val[idx];
                r.slot   = SLOT_W'(idx);
            end
            else
            begin
                bkt_state[idx] = SLOT_DELETED;
                bkt_val[idx]   = '0;
                if (live_entries > 0)
                    live_entries--;
                r.status = RES_DELETED;
                r.slot   = SLOT_W'(idx);
            end
        end
        return r;
    endfunction

    // A name of one to eight characters from 0x41 to 0x7a, unused upper bytes zero.
    function automatic logic [63:0] make_name();
        logic [63:0] k;
        int          len;
        int          b;
        k = '0;
        len = $urandom_range(1, 8);
        for (b = 0; b < len; b++)
            k[8*b +: 8] = 8'($urandom_range(8'h41, 8'h7a));
        return k;
    endfunction

    function automatic dir_row_t size_row(input logic [SIZE_W-1:0] v);
        dir_row_t row;
        row = '{default: 0};
        row.sets_size = 1'b1;
        row.size_val  = v;
        return row;
    endfunction

    function automatic dir_row_t req_row(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] val,
                                         input bit typed = 1'b0,
                                         input logic [RES_W-1:0] st = RES_INVALID,
                                         input logic [VALUE_W-1:0] fv = '0,
                                         input logic [SLOT_W-1:0] sl = '0);
        dir_row_t row;
        row = '{default: 0};
        row.op    = op;
        row.key   = key;
        row.val   = val;
        row.typed = typed;
        row.ans   = '{status: st, value: fv, slot: sl};
        return row;
    endfunction

    task automatic send_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] val, input bit typed,
                            input answer_t typed_ans);
        answer_t predicted;
        s_tdata  <= {6'b0, val, key, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_table_op(op, key, val);
        answer_q.push_back(typed ? typed_ans : predicted);
    endtask

    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic write_table_size(input logic [SIZE_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_TABLE_SIZE);
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg = v;
    endtask

    // Result checker and receiver back-pressure.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected result beat: status %0d value %h slot %0d",
                         $time, m_tdata[2:0], m_tdata[66:3], m_tdata[70:67]);
                errors++;
            end
            else
            begin
                head_ans = answer_q.pop_front();
                if (m_tdata[2:0] !== head_ans.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, head_ans.status, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[66:3] !== head_ans.value)
                begin
                    $display("%0t: found_value expected %h got %h",
                             $time, head_ans.value, m_tdata[66:3]);
                    errors++;
                end
                if (m_tdata[70:67] !== head_ans.slot)
                begin
                    $display("%0t: slot expected %0d got %0d",
                             $time, head_ans.slot, m_tdata[70:67]);
                    errors++;
                end
            end
        end
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          p;
        int          i;
        int          gap;
        int          pick;
        logic [1:0]  op;
        logic [63:0] key;
        logic [63:0] val;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        size_reg = TABLE_SIZE_RESET;
        live_entries = 0;
        for (i = 0; i < MAX_SLOTS; i++)
        begin
            bkt_state[i] = SLOT_EMPTY;
            bkt_key[i]   = '0;
            bkt_val[i]   = '0;
        end
        for (i = 0; i < NAME_POOL; i++)
            name_pool[i] = make_name();

        // Empty table at size 16, then zero keys, the unused operation code, two inserts and a lookup.
        dir_rows.push_back(req_row(OP_LOOKUP, 64'h41, 64'h0, 1, RES_NOT_FOUND));
        dir_rows.push_back(req_row(OP_DELETE, 64'h41, 64'h0, 1, RES_NOT_FOUND));
        dir_rows.push_back(req_row(OP_INSERT, 64'h0, ONES64, 1, RES_INVALID));
        dir_rows.push_back(req_row(OP_LOOKUP, 64'h0, 64'h0, 1, RES_INVALID));
        dir_rows.push_back(req_row(OP_DELETE, 64'h0, 64'h0, 1, RES_INVALID));
        dir_rows.push_back(req_row(2'd3, 64'h41, ONES64, 1, RES_INVALID));
        dir_rows.push_back(req_row(OP_INSERT, 64'h41, 64'h1, 1, RES_INSERTED, 64'h0, 4'd1));
        dir_rows.push_back(req_row(OP_INSERT, ONES64, ONES64, 1, RES_INSERTED, 64'h0, 4'd8));
        dir_rows.push_back(req_row(OP_LOOKUP, ONES64, 64'h0, 1, RES_FOUND, ONES64, 4'd8));
        // Duplicate insert, a collision on the same home slot, and probing past a
        // deleted slot.
        dir_rows.push_back(req_row(OP_INSERT, 64'h41, 64'h2));
        dir_rows.push_back(req_row(OP_INSERT, 64'h51, 64'h3));
        dir_rows.push_back(req_row(OP_DELETE, 64'h41, 64'h0));
        dir_rows.push_back(req_row(OP_LOOKUP, 64'h41, 64'h0));
        dir_rows.push_back(req_row(OP_LOOKUP, 64'h51, 64'h0));
        dir_rows.push_back(req_row(OP_INSERT, 64'h8000_0000_0000_0000, 64'h0));
        dir_rows.push_back(req_row(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h0));
        dir_rows.push_back(req_row(OP_DELETE, ONES64, 64'h0));
        dir_rows.push_back(req_row(OP_DELETE, ONES64, 64'h0));
        // A zero size acts as one; entries above the new size still count as live.
        dir_rows.push_back(size_row(5'd0));
        dir_rows.push_back(req_row(OP_INSERT, 64'h61, 64'h4));
        dir_rows.push_back(req_row(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h0));
        dir_rows.push_back(size_row(5'd31));
        dir_rows.push_back(req_row(OP_LOOKUP, 64'h51, 64'h0));
        dir_rows.push_back(size_row(5'd2));
        dir_rows.push_back(req_row(OP_INSERT, 64'h4242, 64'h5));
        dir_rows.push_back(req_row(OP_DELETE, 64'h8000_0000_0000_0000, 64'h0));
        dir_rows.push_back(req_row(OP_LOOKUP, 64'h41, 64'h0));

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].sets_size)
            begin
                wait_drained(SETTLE_CYCLES);
                write_table_size(dir_rows[i].size_val);
            end
            else
                send_req(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val,
                         dir_rows[i].typed, dir_rows[i].ans);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained(SETTLE_CYCLES);
            write_table_size(SIZE_W'(phase_size[p]));
            send_idle_pct  = (p % 4 == 1) ? 79 : (p % 4 == 3) ? 33 : 0;
            recv_stall_pct = (p % 4 == 2) ? 79 : (p % 4 == 3) ? 33 : 0;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 80)
                    key = name_pool[$urandom_range(0, NAME_POOL - 1)];
                else
                    key = {$urandom, $urandom};
                val = {$urandom, $urandom};
                if (pick < 2)
                begin
                    op = 2'($urandom_range(0, 3));
                    key = '0;
                end
                else if (pick < 4)
                    op = 2'd3;
                else if (pick < 40)
                    op = OP_INSERT;
                else if (pick < 70)
                    op = OP_LOOKUP;
                else
                    op = OP_DELETE;
                send_req(op, key, val, 1'b0, '0);

                // Now and then the sender holds off until the block has answered all.
                if ($urandom_range(0, 63) == 0)
                    wait_drained(0);
                else
                begin
                    gap = 0;
                    while (gap < 50 && $urandom_range(0, 99) < send_idle_pct)
                        gap++;
                    if (gap > 0)
                    begin
                        s_tvalid <= 1'b0;
                        repeat (gap)
                            @(posedge clk);
                    end
                end
            end
        end

        wait_drained(SETTLE_CYCLES);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
